### src/spg_pkg.sv
// Shared types and constants for the staged point radius gate.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package spg_pkg;

    localparam int COORD_W        = 24;
    localparam int REQ_W          = 2;
    localparam int RADIUS_W       = 16;
    localparam int RADIUS_SQ_W    = 2 * RADIUS_W;
    localparam int SQ_W           = 2 * COORD_W;
    localparam int DIST_W         = SQ_W + 2;
    localparam int IN_DATA_W      = 3 * COORD_W;
    localparam int OUT_DATA_W     = 8;
    localparam int RADIUS_RESET   = 150;
    localparam int MAX_POINTS_DEF = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_QUERY  = 2'd3
    } req_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic out_load;
    } spg_cmd_t;

    typedef struct packed {
        logic in_is_query;
        logic scan_done;
        logic out_free;
    } spg_stat_t;

endpackage

`default_nettype wire

### src/spg_ctrl.sv
// Request sequencer for the staged point radius gate.
// Depends on spg_pkg; drives commands to spg_datapath.
`default_nettype none

module spg_ctrl
    import spg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire spg_stat_t stat,
    output spg_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.accept   = s_tvalid && s_tready;
    assign cmd.scan     = (state_reg == ST_SCAN);
    assign cmd.out_load = (state_reg == ST_DONE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = stat.in_is_query ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start processing");

    a_load_only_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a pending beat");

endmodule

`default_nettype wire

### src/spg_datapath.sv
// Point table, counts, distance pipeline and output register.
// Depends on spg_pkg; commanded by spg_ctrl.
`default_nettype none

module spg_datapath
    import spg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire spg_cmd_t              cmd,
    output spg_stat_t                  stat,
    input  wire logic [REQ_W-1:0]      s_tuser,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  cfg_valid,
    input  wire logic [RADIUS_W-1:0]   cfg_data,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [IN_DATA_W-1:0] point_mem [MAX_POINTS];

    logic [CNT_W-1:0]       staged_reg, staged_next;
    logic [CNT_W-1:0]       published_reg, published_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [RADIUS_SQ_W-1:0] radius_sq_reg;
    logic                   is_query_reg;
    logic                   dropped_reg;
    logic                   hit_reg, hit_next;
    logic                   out_valid_reg;
    logic                   out_covered_reg;
    logic                   out_dropped_reg;

    logic [COORD_W-1:0]     qx_reg, qy_reg, qz_reg;
    logic [IN_DATA_W-1:0]   rd_data_reg;
    logic [COORD_W-1:0]     mag_x_reg, mag_y_reg, mag_z_reg;
    logic [SQ_W-1:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic                   v1_reg, v2_reg, v3_reg;

    logic                   full;
    logic                   issue;
    logic                   in_add;
    logic [COORD_W-1:0]     mag_x, mag_y, mag_z;
    logic [DIST_W-1:0]      dist_sum;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d_ab;
        logic signed [COORD_W:0] d_ba;
        d_ab = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        d_ba = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
        return d_ab[COORD_W] ? d_ba[COORD_W-1:0] : d_ab[COORD_W-1:0];
    endfunction

    assign full   = (staged_reg == CNT_W'(MAX_POINTS));
    assign in_add = cmd.accept && (req_t'(s_tuser) == REQ_ADD);
    assign issue  = cmd.scan && (idx_reg != published_reg);

    assign stat.in_is_query = (req_t'(s_tuser) == REQ_QUERY);
    assign stat.scan_done   = (idx_reg == published_reg) && !v1_reg && !v2_reg && !v3_reg;
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_dropped_reg, out_covered_reg};

    always_comb
    begin
        staged_next    = staged_reg;
        published_next = published_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        if (cmd.accept)
        begin
            case (req_t'(s_tuser))
                REQ_CLEAR:
                begin
                    staged_next    = '0;
                    published_next = '0;
                end
                REQ_ADD:
                begin
                    if (!full)
                    begin
                        staged_next = staged_reg + CNT_W'(1);
                    end
                end
                REQ_COMMIT:
                begin
                    published_next = staged_reg;
                end
                REQ_QUERY:
                begin
                    idx_next = '0;
                    hit_next = 1'b0;
                end
                default:
                begin
                    staged_next = staged_reg;
                end
            endcase
        end
        else
        begin
            if (issue)
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            if (v3_reg && (dist_sum <= DIST_W'(radius_sq_reg)))
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_reg    <= '0;
            published_reg <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            radius_sq_reg <= RADIUS_SQ_W'(RADIUS_RESET * RADIUS_RESET);
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            staged_reg    <= staged_next;
            published_reg <= published_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            if (cfg_valid)
            begin
                radius_sq_reg <= RADIUS_SQ_W'(cfg_data) * RADIUS_SQ_W'(cfg_data);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_add && !full)
        begin
            point_mem[staged_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (issue)
        begin
            rd_data_reg <= point_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        mag_x    = abs_diff(qx_reg, rd_data_reg[COORD_W-1:0]);
        mag_y    = abs_diff(qy_reg, rd_data_reg[2*COORD_W-1:COORD_W]);
        mag_z    = abs_diff(qz_reg, rd_data_reg[3*COORD_W-1:2*COORD_W]);
        dist_sum = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            qx_reg       <= s_tdata[COORD_W-1:0];
            qy_reg       <= s_tdata[2*COORD_W-1:COORD_W];
            qz_reg       <= s_tdata[3*COORD_W-1:2*COORD_W];
            is_query_reg <= (req_t'(s_tuser) == REQ_QUERY);
            dropped_reg  <= in_add && full;
        end
        mag_x_reg <= mag_x;
        mag_y_reg <= mag_y;
        mag_z_reg <= mag_z;
        sq_x_reg  <= SQ_W'(mag_x_reg) * SQ_W'(mag_x_reg);
        sq_y_reg  <= SQ_W'(mag_y_reg) * SQ_W'(mag_y_reg);
        sq_z_reg  <= SQ_W'(mag_z_reg) * SQ_W'(mag_z_reg);
        if (cmd.out_load)
        begin
            out_covered_reg <= is_query_reg && hit_reg;
            out_dropped_reg <= dropped_reg;
        end
    end

    a_staged_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        staged_reg <= CNT_W'(MAX_POINTS))
        else $error("staged count exceeds table size");

    a_published_le_staged: assert property (
        @(posedge clk) disable iff (!rst_n)
        published_reg <= staged_reg)
        else $error("published count ahead of staged count");

endmodule

`default_nettype wire

### src/staged_point_radius_gate.sv
// Top level of the staged point radius gate: one controller, one datapath.
// Depends on spg_pkg, spg_ctrl and spg_datapath.
//
// Usage:
//   Input stream s_*: s_tuser carries the request (clear, add, commit,
//   query); s_tdata carries x, y, z as signed 24-bit values. Every request
//   returns exactly one beat on m_*: m_tdata bit 0 is covered (query hit),
//   bit 1 is dropped (add to a full table); other bits are zero.
//   cfg_* writes the 16-bit radius; cfg_ready is always high. Write it
//   only while no request is in flight.
// Sequencing and throughput:
//   Clear, add and commit go straight to the done state, which loads the result.
//   A query walks the published table one entry per cycle through a
//   four-stage read, difference, square and compare pipeline; the scan
//   ends once the pipeline drains, and the done state loads the result.
//   One request is in flight at a time; the next request is accepted in the
//   cycle after the previous result enters the output register.
// Reset:
//   Counts clear and the radius returns to 150; the table needs no clear.
// Stall:
//   A waiting result holds on m_* while m_tready is low; a finished request
//   then waits for the output register before the next one is accepted.
`default_nettype none

module staged_point_radius_gate
    import spg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pos_x, pos_y, pos_z
    input  wire logic [REQ_W-1:0]      s_tuser,   // req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // covered, dropped, zero pad
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [RADIUS_W-1:0]   cfg_data
);

    spg_cmd_t  cmd;
    spg_stat_t stat;

    assign cfg_ready = 1'b1;

    spg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spg_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
